// ===== sv/u16u8_pkg.sv =====
package u16u8_pkg;

  localparam int unsigned UnitW = 21;
  localparam int unsigned ByteW = 8;
  localparam int unsigned MaxBytes = 4;
  localparam int unsigned LenW = 3;
  localparam int unsigned SurrTagW = UnitW - 10;

  localparam logic [SurrTagW-1:0] HiSurrTag = 11'h036;
  localparam logic [SurrTagW-1:0] LoSurrTag = 11'h037;
  localparam logic [UnitW-1:0] SuppBase = 21'h010000;

  localparam logic [UnitW-1:0] Max1Byte = 21'h00007f;
  localparam logic [UnitW-1:0] Max2Byte = 21'h0007ff;
  localparam logic [UnitW-1:0] Max3Byte = 21'h00ffff;

  localparam logic [LenW-1:0] Len1 = 3'd1;
  localparam logic [LenW-1:0] Len2 = 3'd2;
  localparam logic [LenW-1:0] Len3 = 3'd3;
  localparam logic [LenW-1:0] Len4 = 3'd4;

  typedef struct packed {
    logic [MaxBytes*ByteW-1:0] bytes;
    logic [LenW-1:0]           len;
  } enc_t;

  function automatic enc_t utf8_encode(input logic [UnitW-1:0] cp);
    enc_t e;
    if (cp <= Max1Byte) begin
      e.bytes = {1'b0, cp[6:0], 24'h000000};
      e.len   = Len1;
    end else if (cp <= Max2Byte) begin
      e.bytes = {3'b110, cp[10:6], 2'b10, cp[5:0], 16'h0000};
      e.len   = Len2;
    end else if (cp <= Max3Byte) begin
      e.bytes = {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'h00};
      e.len   = Len3;
    end else begin
      e.bytes = {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6],
                 2'b10, cp[5:0]};
      e.len   = Len4;
    end
    return e;
  endfunction

endpackage

// ===== sv/u16u8_front.sv =====
module u16u8_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [u16u8_pkg::UnitW-1:0]   in_code_unit,
  input  logic                          in_end_of_text,
  output logic                          enc_valid,
  input  logic                          enc_ready,
  output u16u8_pkg::enc_t               enc
);
  import u16u8_pkg::*;

  logic             vld_r, vld_nxt;
  logic [UnitW-1:0] unit_r;
  logic             eot_r;
  logic [UnitW-1:0] pend_r, pend_nxt;
  logic             is_hi, is_lo, advance;
  logic [UnitW-1:0] cp, hi_offset;

  assign is_hi = (unit_r[UnitW-1:10] == HiSurrTag);
  assign is_lo = (unit_r[UnitW-1:10] == LoSurrTag);
  assign hi_offset = {1'b0, unit_r[9:0], 10'h000} + SuppBase;
  assign cp = is_lo ? (pend_r | {11'h000, unit_r[9:0]}) : unit_r;

  assign enc       = utf8_encode(cp);
  assign enc_valid = vld_r && !is_hi;
  assign advance   = vld_r && (is_hi || enc_ready);
  assign in_ready  = !vld_r || advance;

  always_comb begin
    vld_nxt = vld_r;
    if (advance) begin
      vld_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end
    pend_nxt = pend_r;
    if (advance) begin
      pend_nxt = (is_hi && !eot_r) ? hi_offset : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      pend_r <= '0;
    end else begin
      vld_r  <= vld_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      unit_r <= in_code_unit;
      eot_r  <= in_end_of_text;
    end
  end

  a_pend_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r != '0) |-> (pend_r[9:0] == 10'h000 && pend_r >= SuppBase))
    else $error("pending point lost its alignment");

  a_hi_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && is_hi) |=> (pend_r == '0 || pend_r[9:0] == 10'h000))
    else $error("high surrogate left a bad pending point");

endmodule

// ===== sv/u16u8_serial.sv =====
module u16u8_serial (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          enc_valid,
  output logic                          enc_ready,
  input  u16u8_pkg::enc_t               enc,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [u16u8_pkg::ByteW-1:0]   out_utf8_byte,
  output logic                          out_last_byte
);
  import u16u8_pkg::*;

  localparam int unsigned BufW = MaxBytes * ByteW;

  logic [BufW-1:0] buf_r, buf_nxt;
  logic [LenW-1:0] rem_r, rem_nxt;
  logic            take, load;

  assign out_valid     = (rem_r != '0);
  assign out_utf8_byte = buf_r[BufW-1 -: ByteW];
  assign out_last_byte = (rem_r == Len1);
  assign take          = out_valid && out_ready;
  assign enc_ready     = !out_valid || (take && out_last_byte);
  assign load          = enc_valid && enc_ready;

  always_comb begin
    buf_nxt = buf_r;
    rem_nxt = rem_r;
    if (take) begin
      buf_nxt = {buf_r[BufW-ByteW-1:0], {ByteW{1'b0}}};
      rem_nxt = rem_r - Len1;
    end
    if (load) begin
      buf_nxt = enc.bytes;
      rem_nxt = enc.len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= Len4)
    else $error("byte count out of range");

  a_drain_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (take && out_last_byte && !load) |=> !out_valid)
    else $error("bytes shown after the last one");

  a_cont_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !out_last_byte) |=> (out_utf8_byte[7:6] == 2'b10))
    else $error("continuation byte malformed");

endmodule

// ===== sv/utf16_to_utf8_encoder.sv =====
// UTF-16 to UTF-8 encoder. One code unit (UTF-16 unit or direct code point up to 21 bits)
// is taken per item into an input register, which can accept a new item in every cycle
// it is free; it is encoded in one pass into a result register that sends one byte per
// cycle while out_ready is high, so a unit gives one to four bytes, the length of its
// UTF-8 form, and a high surrogate leaves the input register with no byte. The first byte
// is shown from the result register, after the input register; the next unit is taken
// while the last byte of the previous one is still waiting. A high surrogate is held and
// joined with a following low surrogate; any other unit drops it, and end_of_text
// drops a high surrogate that arrives with it. A zero unit is encoded as byte 0x00.
module utf16_to_utf8_encoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [u16u8_pkg::UnitW-1:0]   in_code_unit,
  input  logic                          in_end_of_text,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [u16u8_pkg::ByteW-1:0]   out_utf8_byte,
  output logic                          out_last_byte
);
  import u16u8_pkg::*;

  logic enc_valid, enc_ready;
  enc_t enc;

  u16u8_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_code_unit   (in_code_unit),
    .in_end_of_text (in_end_of_text),
    .enc_valid      (enc_valid),
    .enc_ready      (enc_ready),
    .enc            (enc)
  );

  u16u8_serial u_serial (
    .clk           (clk),
    .rst_n         (rst_n),
    .enc_valid     (enc_valid),
    .enc_ready     (enc_ready),
    .enc           (enc),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_utf8_byte (out_utf8_byte),
    .out_last_byte (out_last_byte)
  );

endmodule
